>>> rtl/ibp_pkg.sv
// Package for the interleaved bit packer: transaction payload types and fixed constants.
// No dependencies; used by every module of the block.
`default_nettype none

package ibp_pkg;

  localparam int LANES     = 4;
  localparam int WORD_BITS = 32;
  localparam int WIDTH_W   = 6;   // bit_width field
  localparam int OFFS_W    = 5;   // fill offset inside one lane word

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WIDTH_W-1:0]   width_t;
  typedef logic [OFFS_W-1:0]    offs_t;

  typedef struct packed {
    logic [31:0] lane_value_0;
    logic [31:0] lane_value_1;
    logic [31:0] lane_value_2;
    logic [31:0] lane_value_3;
    logic [5:0]  bit_width;
  } in_item_t;

  typedef struct packed {
    logic [31:0] packed_word_0;
    logic [31:0] packed_word_1;
    logic [31:0] packed_word_2;
    logic [31:0] packed_word_3;
    logic        block_done;
    logic        width_error;
  } out_item_t;

  // Per-lane control, shared by all lanes for one accepted transaction
  typedef struct packed {
    logic   en;      // lane packs this value
    logic   clear;   // block ends, accumulator back to zero
    logic   full;    // lane word fills on this value
    offs_t  fill;
    width_t width;
  } lane_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/interleaved_bit_packer_top.sv
// Interleaved bit packer, top level: block control, four packing lanes, merge stage.
// Depends on ibp_pkg, ibp_lane, ibp_merge.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries four lane values and a width.
//   ITEMS_PER_BLOCK transactions make one block; the width is taken from the
//   first transaction of a block. Output channel out_valid/out_stall/out_data
//   carries one 128-bit packed word (four lane words) per filled word, with
//   block_done on the last word of a block, or one width_error result for a
//   block whose width exceeds 32. A zero-width block emits nothing.
//   Throughput: one input transaction per cycle while in_stall is low, set by the
//   combinational mask/shift/OR in each lane. Each result is registered before it
//   appears on out_valid.
//   When the receiver stalls, a result waits in the output register and a
//   second one in a skid register; in_stall rises only while the skid holds one.
//   Reset (rst_n low, synchronous) clears the accumulators, fill offset, block
//   position and the valid flags of both output registers.
`default_nettype none

module interleaved_bit_packer_top #(
  parameter int ITEMS_PER_BLOCK = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire ibp_pkg::in_item_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      ibp_pkg::out_item_t out_data
);

  localparam int CNT_W = (ITEMS_PER_BLOCK > 1) ? $clog2(ITEMS_PER_BLOCK) : 1;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  ibp_pkg::offs_t    fill_r, fill_nxt;
  ibp_pkg::width_t   bw_r, bw_nxt;
  logic              disc_r, disc_nxt;

  logic              in_accept, first, last, err, discard, active, full, emit;
  ibp_pkg::width_t   width;
  logic [ibp_pkg::WIDTH_W-1:0] nfill;
  ibp_pkg::lane_ctrl_t ctrl;
  logic [ibp_pkg::LANES-1:0][ibp_pkg::WORD_BITS-1:0] lane_in, lane_word;

  assign in_accept = in_valid && !in_stall;
  assign first     = (cnt_r == '0);
  assign last      = (cnt_r == CNT_W'(ITEMS_PER_BLOCK - 1));
  assign width     = first ? in_data.bit_width : bw_r;
  assign err       = first && (in_data.bit_width > ibp_pkg::WIDTH_W'(ibp_pkg::WORD_BITS));
  assign discard   = first ? err : disc_r;
  assign active    = !discard && (width != '0);
  assign nfill     = {1'b0, fill_r} + width;
  assign full      = (nfill >= ibp_pkg::WIDTH_W'(ibp_pkg::WORD_BITS));
  assign emit      = active && (full || last);

  always_comb begin
    ctrl.en    = in_accept && active;
    ctrl.clear = in_accept && last;
    ctrl.full  = full;
    ctrl.fill  = fill_r;
    ctrl.width = width;
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    fill_nxt = fill_r;
    bw_nxt   = bw_r;
    disc_nxt = disc_r;
    if (in_accept) begin
      if (first) begin
        bw_nxt   = in_data.bit_width;
        disc_nxt = err;
      end
      if (last) begin
        cnt_nxt  = '0;
        fill_nxt = '0;
        disc_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (active) begin
          fill_nxt = nfill[ibp_pkg::OFFS_W-1:0];  // wraps by WORD_BITS when full
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      fill_r <= '0;
      bw_r   <= '0;
      disc_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      fill_r <= fill_nxt;
      bw_r   <= bw_nxt;
      disc_r <= disc_nxt;
    end
  end

  assign lane_in[0] = in_data.lane_value_0;
  assign lane_in[1] = in_data.lane_value_1;
  assign lane_in[2] = in_data.lane_value_2;
  assign lane_in[3] = in_data.lane_value_3;

  for (genvar g = 0; g < ibp_pkg::LANES; g++) begin : g_lane
    ibp_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .value (lane_in[g]),
      .ctrl  (ctrl),
      .word  (lane_word[g])
    );
  end

  ibp_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (in_accept && (err || emit)),
    .words       (lane_word),
    .block_done  (last),
    .width_error (err),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .in_stall    (in_stall)
  );

  // error results carry nothing else
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.width_error |->
      !out_data.block_done && out_data.packed_word_0 == '0 && out_data.packed_word_3 == '0)
    else $error("width error result carries data");

  // input only backs up behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // a block always starts on a clean word
  a_fill_start: assert property (@(posedge clk) disable iff (!rst_n)
    first |-> fill_r == '0)
    else $error("nonzero fill offset at block start");

  // last transaction of a block wraps the position
  a_block_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && last |=> cnt_r == '0 && !disc_r)
    else $error("block position did not wrap");

endmodule

`default_nettype wire

>>> rtl/ibp_lane.sv
// One packing lane: masks a value, ORs it into the lane accumulator, handles spill.
// Depends on ibp_pkg.
`default_nettype none

module ibp_lane (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ibp_pkg::word_t     value,
  input  wire ibp_pkg::lane_ctrl_t ctrl,
  output      ibp_pkg::word_t     word
);

  ibp_pkg::word_t acc_r, acc_nxt;
  ibp_pkg::word_t vmask, v, acc_or, spill;
  logic [ibp_pkg::WIDTH_W-1:0] rshift;

  always_comb begin
    if (ctrl.width >= ibp_pkg::WIDTH_W'(ibp_pkg::WORD_BITS)) begin
      vmask = '1;
    end else begin
      vmask = (ibp_pkg::word_t'(1) << ctrl.width) - ibp_pkg::word_t'(1);
    end
    v      = value & vmask;
    acc_or = acc_r | (v << ctrl.fill);
    // high bits that did not fit start the next word; zero when the word filled exactly
    rshift = ibp_pkg::WIDTH_W'(ibp_pkg::WORD_BITS) - {1'b0, ctrl.fill};
    spill  = v >> rshift;
    if (ctrl.fill == '0) begin
      spill = '0;
    end
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.en) begin
      acc_nxt = ctrl.full ? spill : acc_or;
    end
  end

  assign word = acc_or;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ibp_merge.sv
// Merge stage: combines the lane words into one result transaction, with output
// register and skid register. Depends on ibp_pkg.
`default_nettype none

module ibp_merge (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   res_valid,
  input  wire logic [ibp_pkg::LANES-1:0][ibp_pkg::WORD_BITS-1:0] words,
  input  wire logic                                   block_done,
  input  wire logic                                   width_error,
  input  wire logic                                   out_stall,
  output      logic                                   out_valid,
  output      ibp_pkg::out_item_t                     out_data,
  output      logic                                   in_stall
);

  ibp_pkg::out_item_t res, od_r, sd_r;
  logic ov_r, sv_r, out_fire;

  always_comb begin
    res = '0;
    if (width_error) begin
      res.width_error = 1'b1;
    end else begin
      res.packed_word_0 = words[0];
      res.packed_word_1 = words[1];
      res.packed_word_2 = words[2];
      res.packed_word_3 = words[3];
      res.block_done    = block_done;
    end
  end

  assign out_fire  = ov_r && !out_stall;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign in_stall  = sv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (sv_r) begin
      if (out_fire) begin
        sv_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!ov_r || out_fire) begin
        ov_r <= 1'b1;
      end else begin
        sv_r <= 1'b1;
      end
    end else if (out_fire) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv_r) begin
      if (out_fire) begin
        od_r <= sd_r;
      end
    end else if (res_valid) begin
      if (!ov_r || out_fire) begin
        od_r <= res;
      end else begin
        sd_r <= res;
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Testbench for interleaved_bit_packer_top: drives blocks of four-lane values and checks
// every packed word against a cycle-free model of the packer. Depends on ibp_pkg and the RTL.
`default_nettype none

module tb_top;

  localparam int BLOCK_ITEMS = 32;

  typedef enum int {PAT_RANDOM, PAT_ONES, PAT_ZEROS, PAT_MIXED} fill_pattern_t;

  // Packing model plus the queue of packed words still owed by the block
  class packed_word_scoreboard;
    ibp_pkg::word_t     lane_acc[ibp_pkg::LANES];
    int unsigned        fill_pos;
    int unsigned        item_pos;
    ibp_pkg::width_t    blk_width;
    bit                 dropping;
    int unsigned        block_items;
    ibp_pkg::out_item_t owed_words[$];
    int unsigned        mismatches;

    function new(int unsigned items);
      block_items = items;
      mismatches  = 0;
      blk_width   = '0;
      clear_block();
    endfunction

    function void clear_block();
      foreach (lane_acc[i]) lane_acc[i] = '0;
      fill_pos = 0;
      item_pos = 0;
      dropping = 1'b0;
    endfunction

    function int unsigned pending();
      return owed_words.size();
    endfunction

    // Advance the model by one accepted input transaction
    function void pack_item(ibp_pkg::in_item_t it);
      ibp_pkg::word_t     lane_in[ibp_pkg::LANES];
      ibp_pkg::word_t     words[ibp_pkg::LANES];
      ibp_pkg::word_t     vmask;
      ibp_pkg::word_t     v;
      ibp_pkg::word_t     acc;
      int unsigned        nfill;
      bit                 last;
      bit                 emit;
      bit                 err;
      ibp_pkg::out_item_t r;
      lane_in[0] = it.lane_value_0;
      lane_in[1] = it.lane_value_1;
      lane_in[2] = it.lane_value_2;
      lane_in[3] = it.lane_value_3;
      foreach (words[i]) words[i] = '0;
      emit = 1'b0;
      err  = 1'b0;
      if (item_pos == 0) begin
        blk_width = it.bit_width;
        dropping  = 1'b0;
        if (blk_width > ibp_pkg::WORD_BITS) begin
          dropping = 1'b1;
          err      = 1'b1;
        end
      end
      last = (item_pos + 1 >= block_items);
      if (!dropping && blk_width != 0) begin
        nfill = fill_pos + blk_width;
        vmask = (blk_width >= ibp_pkg::WORD_BITS) ? '1 :
                (ibp_pkg::word_t'(1) << blk_width) - ibp_pkg::word_t'(1);
        for (int i = 0; i < ibp_pkg::LANES; i++) begin
          v   = lane_in[i] & vmask;
          acc = lane_acc[i] | (v << fill_pos);
          if (nfill >= ibp_pkg::WORD_BITS) begin
            words[i] = acc;
            // high bits that did not fit start the next lane word
            acc = (nfill > ibp_pkg::WORD_BITS) ? (v >> (ibp_pkg::WORD_BITS - fill_pos)) : '0;
          end
          lane_acc[i] = acc;
        end
        if (nfill >= ibp_pkg::WORD_BITS) begin
          emit  = 1'b1;
          nfill = nfill - ibp_pkg::WORD_BITS;
        end else if (last) begin
          foreach (words[i]) words[i] = lane_acc[i];
          emit = 1'b1;
        end
        fill_pos = nfill;
      end
      r = '0;
      if (err) begin
        r.width_error = 1'b1;
        owed_words.push_back(r);
      end else if (emit) begin
        r.packed_word_0 = words[0];
        r.packed_word_1 = words[1];
        r.packed_word_2 = words[2];
        r.packed_word_3 = words[3];
        r.block_done    = last;
        owed_words.push_back(r);
      end
      if (last) clear_block();
      else item_pos++;
    endfunction

    function void check_word(ibp_pkg::out_item_t got);
      ibp_pkg::out_item_t want;
      bit                 bad;
      if (owed_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected packed word: got %h", got);
        return;
      end
      want = owed_words.pop_front();
      bad = (got.packed_word_0 !== want.packed_word_0) ||
            (got.packed_word_1 !== want.packed_word_1) ||
            (got.packed_word_2 !== want.packed_word_2) ||
            (got.packed_word_3 !== want.packed_word_3) ||
            (got.block_done    !== want.block_done)    ||
            (got.width_error   !== want.width_error);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("packed word mismatch: expected %h done=%b err=%b, got %h done=%b err=%b",
                   {want.packed_word_3, want.packed_word_2, want.packed_word_1,
                    want.packed_word_0}, want.block_done, want.width_error,
                   {got.packed_word_3, got.packed_word_2, got.packed_word_1,
                    got.packed_word_0}, got.block_done, got.width_error);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  ibp_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ibp_pkg::out_item_t out_data;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned blocks_sent;

  packed_word_scoreboard sb;

  interleaved_bit_packer_top #(.ITEMS_PER_BLOCK(BLOCK_ITEMS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_data);
  end

  function automatic ibp_pkg::word_t lane_value(fill_pattern_t pat);
    ibp_pkg::word_t v;
    case (pat)
      PAT_ONES:  v = '1;
      PAT_ZEROS: v = '0;
      PAT_MIXED: begin
        case ($urandom_range(3))
          0:       v = '1;
          1:       v = '0;
          2:       v = ibp_pkg::word_t'(1) << $urandom_range(ibp_pkg::WORD_BITS - 1);
          default: v = $urandom;
        endcase
      end
      default:   v = $urandom;
    endcase
    return v;
  endfunction

  // idle pattern rotates per block: none, sender only, receiver only, both
  task automatic pick_idling();
    case (blocks_sent % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 58;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 58;
      end
      default: begin
        send_idle_pct  = 29;
        recv_stall_pct = 29;
      end
    endcase
  endtask

  task automatic send_item(ibp_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.pack_item(it);
  endtask

  task automatic send_block(ibp_pkg::width_t w, fill_pattern_t pat);
    ibp_pkg::in_item_t it;
    pick_idling();
    for (int k = 0; k < BLOCK_ITEMS; k++) begin
      it.lane_value_0 = lane_value(pat);
      it.lane_value_1 = lane_value(pat);
      it.lane_value_2 = lane_value(pat);
      it.lane_value_3 = lane_value(pat);
      // width only matters on the first transaction of a block
      it.bit_width    = (k == 0) ? w : ibp_pkg::width_t'($urandom_range(63));
      send_item(it);
    end
    blocks_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    ibp_pkg::width_t w;
    sb             = new(BLOCK_ITEMS);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    blocks_sent    = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: full width, single bit, zero width, just over and far over the limit, 17 bits, full width
    send_block(ibp_pkg::width_t'(32), PAT_ONES);
    send_block(ibp_pkg::width_t'(1), PAT_MIXED);
    send_block(ibp_pkg::width_t'(0), PAT_RANDOM);
    send_block(ibp_pkg::width_t'(33), PAT_RANDOM);
    send_block(ibp_pkg::width_t'(63), PAT_ZEROS);
    send_block(ibp_pkg::width_t'(17), PAT_MIXED);
    send_block(ibp_pkg::width_t'(32), PAT_ZEROS);

    // hold off until the block has delivered everything owed
    wait_drained();

    for (int b = 0; b < 6; b++) begin
      case ($urandom_range(9))
        0:       w = '0;
        1:       w = ibp_pkg::width_t'($urandom_range(63, 33));
        default: w = ibp_pkg::width_t'($urandom_range(32, 1));
      endcase
      send_block(w, ($urandom_range(3) == 0) ? PAT_MIXED : PAT_RANDOM);
    end

    wait_drained();
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
